### sv/rpwd_pkg.sv
// Shared types, constants and register indexes for the pulse-width code decoder.
// No dependencies; every other file of the decoder imports this package.
`default_nettype none

package rpwd_pkg;

    // Fixed widths of the timestamp, registers and result fields.
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned TABLE_N   = 4;
    localparam int unsigned USED_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Default number of code bits per frame.
    localparam int unsigned DEF_CODE_BITS = 32;

    // Register reset values.
    localparam logic [WORD_W-1:0] RST_BIT_THRESHOLD = 32'd500000;
    localparam logic [WORD_W-1:0] RST_MAX_INTERVAL  = 32'd2000000000;
    localparam logic [WORD_W-1:0] RST_GAP_LIMIT     = 32'd2000000000;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [TABLE_N-1:0] t_table;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_THRESHOLD = 3'd0,
        CFG_MAX_INTERVAL  = 3'd1,
        CFG_GAP_LIMIT     = 3'd2,
        CFG_TABLE_A       = 3'd3,
        CFG_TABLE_B       = 3'd4,
        CFG_TABLE_C       = 3'd5,
        CFG_TABLE_D       = 3'd6,
        CFG_ENTRIES_USED  = 3'd7
    } t_cfg_idx;

    // Status of the edge held in the input register, as seen by the frame logic.
    typedef struct packed {
        logic  done;   // this edge closes the frame
        logic  bad;    // a timing fault was seen in the frame
        t_word code;   // code so far, zero when bad, zero-extended
    } t_frame_res;

endpackage

`default_nettype wire

### sv/rf_pulse_width_code_decoder.sv
// Pulse-width code decoder for on-off keyed remote frames: top level.
// Timing: one edge transfer is taken every clock cycle unless the input register
// stalls. An edge passes through an input register, then the frame logic (one
// 32-bit subtract, the threshold compares and the code shift) and the table
// compare settle in the same cycle, and a frame result lands in the output
// register. The input register stalls only when the edge closes a frame while an
// earlier result still waits in the output register.
// Configuration writes are taken at any cycle but must only occur while idle.
// Depends on rpwd_pkg, rpwd_frame_core and rpwd_matcher.
`default_nettype none

module rf_pulse_width_code_decoder #(
    parameter int unsigned CODE_BITS = rpwd_pkg::DEF_CODE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port.
    input  wire logic                          i_cfg_we,
    input  wire logic [rpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire rpwd_pkg::t_word               i_cfg_data,
    // Edge input channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire rpwd_pkg::t_word               i_edge_time,
    // Frame result channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_frame_status,
    output rpwd_pkg::t_word                    o_decoded_code,
    output logic [rpwd_pkg::TABLE_N-1:0]       o_match_mask
);
    import rpwd_pkg::*;

    // Configuration registers.
    t_word             r_bit_threshold;
    t_word             r_max_interval;
    t_word             r_gap_limit;
    t_table            r_table;
    logic [USED_W-1:0] r_entries_used;

    // Input register.
    logic              r_in_valid;
    t_word             r_in_time;

    // Output register.
    logic              r_out_valid;
    logic              r_out_status;
    t_word             r_out_code;
    logic [TABLE_N-1:0] r_out_mask;

    t_frame_res        frame_res;
    logic [TABLE_N-1:0] match_mask;
    logic              advance;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_threshold <= RST_BIT_THRESHOLD;
            r_max_interval  <= RST_MAX_INTERVAL;
            r_gap_limit     <= RST_GAP_LIMIT;
            r_table         <= '0;
            r_entries_used  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BIT_THRESHOLD: r_bit_threshold <= i_cfg_data;
                CFG_MAX_INTERVAL:  r_max_interval  <= i_cfg_data;
                CFG_GAP_LIMIT:     r_gap_limit     <= i_cfg_data;
                CFG_TABLE_A:       r_table[0]      <= i_cfg_data;
                CFG_TABLE_B:       r_table[1]      <= i_cfg_data;
                CFG_TABLE_C:       r_table[2]      <= i_cfg_data;
                CFG_TABLE_D:       r_table[3]      <= i_cfg_data;
                CFG_ENTRIES_USED:  r_entries_used  <= i_cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    // The held edge moves on unless it closes a frame and the output is blocked.
    assign advance    = r_in_valid && (!frame_res.done || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_time <= i_edge_time;
        end
    end

    // Frame state and bit decisions.
    rpwd_frame_core #(
        .CODE_BITS (CODE_BITS)
    ) u_frame_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_edge_time     (r_in_time),
        .i_bit_threshold (r_bit_threshold),
        .i_max_interval  (r_max_interval),
        .i_gap_limit     (r_gap_limit),
        .o_res           (frame_res)
    );

    // Known-code table lookup.
    rpwd_matcher u_matcher (
        .i_code         (frame_res.code),
        .i_bad          (frame_res.bad),
        .i_table        (r_table),
        .i_entries_used (r_entries_used),
        .o_mask         (match_mask)
    );

    // Output register: loaded at frame end, cleared once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && frame_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && frame_res.done) begin
            r_out_status <= frame_res.bad;
            r_out_code   <= frame_res.code;
            r_out_mask   <= match_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out_status;
    assign o_decoded_code = r_out_code;
    assign o_match_mask   = r_out_mask;

    // A held edge that cannot move on keeps its timestamp.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_time))
        else $error("input register lost a stalled edge");

    // A closing edge always leaves a result behind.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && frame_res.done |=> r_out_valid)
        else $error("frame end produced no result");

    // A waiting result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(advance && frame_res.done))
        else $error("pending result overwritten");

    // A rejected frame reports neither a code nor a match.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |-> (r_out_code == '0) && (r_out_mask == '0))
        else $error("rejected frame carries code or match bits");

endmodule

`default_nettype wire

### sv/rpwd_frame_core.sv
// Frame state of the decoder: edge counter, previous timestamp, code shifter, fault flag.
// Depends on rpwd_pkg for the shared word and result types.
`default_nettype none

module rpwd_frame_core #(
    parameter int unsigned CODE_BITS = rpwd_pkg::DEF_CODE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire rpwd_pkg::t_word      i_edge_time,
    input  wire rpwd_pkg::t_word      i_bit_threshold,
    input  wire rpwd_pkg::t_word      i_max_interval,
    input  wire rpwd_pkg::t_word      i_gap_limit,
    output rpwd_pkg::t_frame_res      o_res
);
    import rpwd_pkg::*;

    localparam int unsigned FRAME_EDGES = 2 * CODE_BITS;
    localparam int unsigned CNT_W       = $clog2(FRAME_EDGES + 1);
    localparam logic [CNT_W-1:0] LAST_EDGE = CNT_W'(FRAME_EDGES);
    localparam logic [CNT_W-1:0] FIRST_BIT_EDGE = CNT_W'(2);

    logic [CNT_W-1:0]     r_count;
    t_word                r_prev_time;
    logic                 r_have_prev;
    logic [CODE_BITS-1:0] r_shift;
    logic                 r_bad;

    t_word                interval;
    logic                 restart;
    logic [CNT_W-1:0]     idx;
    logic [CODE_BITS-1:0] shift_base;
    logic                 bad_base;
    logic                 is_bit;
    logic                 fault;
    logic                 bit_val;
    logic [CODE_BITS-1:0] n_shift;
    logic                 n_bad;
    logic                 done;

    // Interval since the previous edge, wrapping, and the long-gap restart.
    always_comb begin
        interval   = i_edge_time - r_prev_time;
        restart    = r_have_prev && (r_count != '0) && (interval >= i_gap_limit);
        idx        = restart ? '0 : r_count;
        shift_base = restart ? '0 : r_shift;
        bad_base   = restart ? 1'b0 : r_bad;
    end

    // Even edges from edge index two on close a bit; classify its pulse length.
    always_comb begin
        is_bit  = (idx >= FIRST_BIT_EDGE) && !idx[0];
        fault   = (interval >= i_max_interval) || (interval == i_bit_threshold);
        bit_val = !fault && (interval > i_bit_threshold);
        n_shift = is_bit ? ((shift_base << 1) | CODE_BITS'(bit_val)) : shift_base;
        n_bad   = bad_base | (is_bit & fault);
        done    = (idx == LAST_EDGE);
    end

    assign o_res.done = done;
    assign o_res.bad  = n_bad;
    assign o_res.code = n_bad ? '0 : WORD_W'(n_shift);

    // State update on each edge that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_prev_time <= '0;
            r_have_prev <= 1'b0;
            r_shift     <= '0;
            r_bad       <= 1'b0;
        end else if (i_step) begin
            r_prev_time <= i_edge_time;
            r_have_prev <= 1'b1;
            if (done) begin
                r_count <= '0;
                r_shift <= '0;
                r_bad   <= 1'b0;
            end else begin
                r_count <= idx + CNT_W'(1);
                r_shift <= n_shift;
                r_bad   <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

### sv/rpwd_matcher.sv
// Compares a decoded code against the enabled entries of the known-code table.
// Depends on rpwd_pkg for the word, table and width constants.
`default_nettype none

module rpwd_matcher (
    input  wire rpwd_pkg::t_word                     i_code,
    input  wire logic                                i_bad,
    input  wire rpwd_pkg::t_table                    i_table,
    input  wire logic [rpwd_pkg::USED_W-1:0]         i_entries_used,
    output logic [rpwd_pkg::TABLE_N-1:0]             o_mask
);
    import rpwd_pkg::*;

    // An entry takes part when its position is below the used count;
    // counts above the table size enable every entry.
    always_comb begin
        for (int n = 0; n < TABLE_N; n++) begin
            o_mask[n] = !i_bad && (i_entries_used > USED_W'(n))
                        && (i_table[n] == i_code);
        end
    end

endmodule

`default_nettype wire

### tb/sv/rf_pulse_width_code_decoder_test.sv
// Self-checking testbench for the pulse-width code decoder: edge timestamps go in through
// a bursty driver, frame results are taken by a stalling monitor and checked field by field.
// Depends on rpwd_pkg and on the decoder RTL (rf_pulse_width_code_decoder and its submodules).
module rf_pulse_width_code_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpwd_pkg::*;

    localparam int unsigned FRAME_EDGES  = 2 * DEF_CODE_BITS;
    localparam t_word       WORD_MAX     = '1;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_EDGES = 400;
    localparam int unsigned MIN_FRAMES   = 30;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef enum int {FAULT_NONE, FAULT_AT_THRESHOLD, FAULT_OVER_MAX} t_fault;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    typedef struct packed {
        logic               status;
        t_word              code;
        logic [TABLE_N-1:0] mask;
    } t_frame_out;

    // Block ports.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    t_word                cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    t_word                edge_time    = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 frame_status;
    t_word                decoded_code;
    logic [TABLE_N-1:0]   match_mask;

    // Register values as last written.
    t_word             thr_reg  = RST_BIT_THRESHOLD;
    t_word             max_reg  = RST_MAX_INTERVAL;
    t_word             gap_reg  = RST_GAP_LIMIT;
    t_table            codes_reg = '0;
    logic [USED_W-1:0] used_reg = '0;

    // Frame state of the predictor.
    logic [6:0] edge_idx   = '0;
    t_word      last_stamp = '0;
    logic       seen_edge  = 1'b0;
    t_word      code_shift = '0;
    logic       frame_bad  = 1'b0;

    // Edge generator and bookkeeping.
    t_word       edge_stamps_q[$];
    t_frame_out  predicted_frames[$];
    t_word       gen_stamp     = '0;
    bit          gen_aligned   = 1'b0;
    int unsigned edges_queued  = 0;
    int unsigned edges_taken   = 0;
    int unsigned frames_queued = 0;
    int unsigned frames_checked = 0;
    int unsigned mismatches    = 0;
    bit          hold_request  = 1'b0;

    // Driver and monitor pacing.
    int unsigned burst_left = 0;
    int unsigned idle_left  = 0;
    int unsigned hold_left  = 0;
    bit          hold_taken = 1'b0;
    t_rx_mode    rx_mode    = RX_OPEN;
    int unsigned mode_left  = 0;

    rf_pulse_width_code_decoder u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_edge_time    (edge_time),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_status (frame_status),
        .o_decoded_code (decoded_code),
        .o_match_mask   (match_mask)
    );

    // Clock with a 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Every mismatch is printed once, up to a cap, and always counted.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic clear_frame();
        edge_idx   = '0;
        code_shift = '0;
        frame_bad  = 1'b0;
    endtask

    // Advance the frame state by one edge and record the frame result it closes, if any.
    task automatic decode_edge(input t_word stamp);
        t_word      span;
        logic [6:0] slot;
        logic       bit_val;
        t_frame_out res;
        int         n;
        span = stamp - last_stamp;
        // A long silence inside a frame restarts it with this edge as edge zero.
        if (seen_edge && edge_idx != 0 && span >= gap_reg) begin
            clear_frame();
        end
        slot = edge_idx;
        // Even edges from two on close a mark and carry one code bit.
        if (slot >= 2 && !slot[0]) begin
            bit_val = 1'b0;
            if (span >= max_reg || span == thr_reg) begin
                frame_bad = 1'b1;
            end else if (span > thr_reg) begin
                bit_val = 1'b1;
            end
            code_shift = {code_shift[WORD_W-2:0], bit_val};
        end
        last_stamp = stamp;
        seen_edge  = 1'b1;
        if (slot >= FRAME_EDGES) begin
            res.status = frame_bad;
            res.code   = frame_bad ? '0 : code_shift;
            res.mask   = '0;
            // A count of entries above four simply enables all of them.
            if (!frame_bad) begin
                for (n = 0; n < TABLE_N; n++) begin
                    if (n < used_reg && codes_reg[n] == code_shift) begin
                        res.mask[n] = 1'b1;
                    end
                end
            end
            predicted_frames.push_back(res);
            clear_frame();
        end else begin
            edge_idx = slot + 1'b1;
        end
    endtask

    // Compare one result transfer with the oldest predicted frame.
    task automatic check_frame();
        t_frame_out want;
        if (predicted_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0b code %h mask %b",
                                      frame_status, decoded_code, match_mask));
            return;
        end
        want = predicted_frames.pop_front();
        if (frame_status !== want.status) begin
            report_mismatch($sformatf("frame %0d status %b, expected %b",
                                      frames_checked, frame_status, want.status));
        end
        if (decoded_code !== want.code) begin
            report_mismatch($sformatf("frame %0d code %h, expected %h",
                                      frames_checked, decoded_code, want.code));
        end
        if (match_mask !== want.mask) begin
            report_mismatch($sformatf("frame %0d mask %b, expected %b",
                                      frames_checked, match_mask, want.mask));
        end
        frames_checked++;
    endtask

    // Edge driver: bursts of transfers separated by random idle gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            idle_left  = 0;
            clear_frame();
            last_stamp = '0;
            seen_edge  = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                decode_edge(edge_time);
                edges_taken++;
            end
            if (!in_valid || in_ready) begin
                if (idle_left != 0) begin
                    idle_left--;
                    in_valid <= 1'b0;
                end else if (edge_stamps_q.size() != 0) begin
                    in_valid  <= 1'b1;
                    edge_time <= edge_stamps_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(48, 1);
                        idle_left  = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: the stall pattern changes at random intervals; one long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                check_frame();
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(3, 0));
                mode_left = $urandom_range(200, 20);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: out_ready <= ($urandom_range(5, 0) == 0);
                    default:   out_ready <= !out_ready;
                endcase
            end
        end
    end

    // Register writes, one per cycle, only while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input t_word value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_BIT_THRESHOLD: thr_reg = value;
            CFG_MAX_INTERVAL:  max_reg = value;
            CFG_GAP_LIMIT:     gap_reg = value;
            CFG_TABLE_A:       codes_reg[0] = value;
            CFG_TABLE_B:       codes_reg[1] = value;
            CFG_TABLE_C:       codes_reg[2] = value;
            CFG_TABLE_D:       codes_reg[3] = value;
            default:           used_reg = value[USED_W-1:0];
        endcase
    endtask

    task automatic program_regs(input t_word thr, input t_word mx, input t_word gap,
                                input t_table codes, input t_word used);
        write_reg(CFG_BIT_THRESHOLD, thr);
        write_reg(CFG_MAX_INTERVAL, mx);
        write_reg(CFG_GAP_LIMIT, gap);
        write_reg(CFG_TABLE_A, codes[0]);
        write_reg(CFG_TABLE_B, codes[1]);
        write_reg(CFG_TABLE_C, codes[2]);
        write_reg(CFG_TABLE_D, codes[3]);
        write_reg(CFG_ENTRIES_USED, used);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Idle means every edge was taken and every frame result checked; then let the pipe drain.
    task automatic wait_idle();
        do @(posedge clk);
        while (edges_taken != edges_queued || predicted_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_stamp(input t_word stamp);
        gen_stamp = stamp;
        edge_stamps_q.push_back(stamp);
        edges_queued++;
    endtask

    task automatic push_edge(input t_word span);
        push_stamp(gen_stamp + span);
    endtask

    function automatic t_word min_word(input t_word a, input t_word b);
        return (a < b) ? a : b;
    endfunction

    // Interval lengths for the current settings.
    function automatic t_word long_gap();
        return $urandom_range(WORD_MAX, gap_reg);
    endfunction

    function automatic t_word space_len();
        t_word hi;
        hi = gap_reg - 1;
        if ($urandom_range(1, 0)) begin
            return $urandom_range(min_word(hi, 5000), 0);
        end
        return $urandom_range(hi, 0);
    endfunction

    function automatic t_word zero_len();
        t_word hi;
        hi = min_word(thr_reg, min_word(max_reg, gap_reg)) - 1;
        if ($urandom_range(7, 0) == 0) begin
            return hi;
        end
        return $urandom_range(hi, 0);
    endfunction

    // Falls back to a zero bit when no interval can decode as one.
    function automatic t_word one_len();
        t_word hi;
        hi = min_word(max_reg, gap_reg) - 1;
        if (thr_reg >= hi) begin
            return zero_len();
        end
        case ($urandom_range(7, 0))
            0:       return thr_reg + 1;
            1:       return hi;
            default: return $urandom_range(hi, thr_reg + 1);
        endcase
    endfunction

    function automatic t_word pick_code();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return codes_reg[$urandom_range(TABLE_N - 1, 0)];
            4:          return '0;
            5:          return WORD_MAX;
            default:    return $urandom();
        endcase
    endfunction

    // Queue one frame of the given code; fewer than a full frame of edges leaves it cut short.
    task automatic queue_frame(input t_word code, input t_fault fault, input int unsigned edges);
        int unsigned bad_bit;
        int unsigned k;
        t_word       span;
        bad_bit = $urandom_range(DEF_CODE_BITS - 1, 0);
        // Open with a long gap unless the decoder is known to sit at edge zero, and now and then even so.
        if (!gen_aligned || $urandom_range(3, 0) == 0) begin
            push_edge(long_gap());
        end else begin
            push_edge(space_len());
        end
        for (k = 1; k < edges; k++) begin
            if (k % 2 == 1) begin
                span = space_len();
            end else if (k / 2 - 1 == bad_bit && fault == FAULT_AT_THRESHOLD
                         && thr_reg < gap_reg) begin
                span = thr_reg;
            end else if (k / 2 - 1 == bad_bit && fault == FAULT_OVER_MAX
                         && max_reg < gap_reg) begin
                span = $urandom_range(gap_reg - 1, max_reg);
            end else if (code[DEF_CODE_BITS - k / 2]) begin
                span = one_len();
            end else begin
                span = zero_len();
            end
            push_edge(span);
        end
        gen_aligned = (edges == FRAME_EDGES + 1);
        if (gen_aligned) begin
            frames_queued++;
        end
    endtask

    // Stray edges: random timestamps, short spaces and long silences.
    task automatic queue_noise(input int unsigned count);
        repeat (count) begin
            case ($urandom_range(2, 0))
                0:       push_stamp($urandom());
                1:       push_edge(space_len());
                default: push_edge(long_gap());
            endcase
        end
        gen_aligned = 1'b0;
    endtask

    // Mostly well-formed frames, some with timing faults, some cut short, some noise.
    task automatic queue_phase(input int unsigned frames);
        int unsigned roll;
        repeat (frames) begin
            roll = $urandom_range(99, 0);
            if (roll < 8) begin
                queue_noise($urandom_range(12, 1));
            end else if (roll < 14) begin
                queue_frame(pick_code(), FAULT_NONE, $urandom_range(FRAME_EDGES, 1));
            end else if (roll < 22) begin
                queue_frame(pick_code(), FAULT_AT_THRESHOLD, FRAME_EDGES + 1);
            end else if (roll < 30) begin
                queue_frame(pick_code(), FAULT_OVER_MAX, FRAME_EDGES + 1);
            end else begin
                queue_frame(pick_code(), FAULT_NONE, FRAME_EDGES + 1);
            end
        end
    endtask

    // Random settings around realistic pulse lengths, with an occasional wild value.
    task automatic random_setup();
        t_word  thr;
        t_word  mx;
        t_word  gap;
        t_table codes;
        int     n;
        thr = $urandom_range(2000000, 50);
        if ($urandom_range(3, 0) == 0) begin
            mx = $urandom() | 1;
        end else begin
            mx = thr + $urandom_range(4 * thr, 1);
        end
        if ($urandom_range(3, 0) == 0) begin
            gap = $urandom() | 1;
        end else if (mx > 32'hF000_0000) begin
            gap = WORD_MAX;
        end else begin
            gap = mx + $urandom_range(100000000, 1);
        end
        // Duplicate entries make several mask bits fire at once.
        for (n = 0; n < TABLE_N; n++) begin
            codes[n] = (n > 0 && $urandom_range(3, 0) == 0) ? codes[n - 1] : $urandom();
        end
        program_regs(thr, mx, gap, codes, ($urandom() << USED_W) | $urandom_range(7, 0));
    endtask

    // Stimulus sequence.
    initial begin
        t_table      codes;
        int unsigned random_base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Timestamp extremes, wrap-around and restarts under the reset settings.
        push_stamp('0);
        push_stamp('0);
        push_stamp(WORD_MAX);
        push_stamp('0);
        push_stamp(32'h8000_0000);
        push_stamp(32'h7FFF_FFFF);
        push_stamp(32'h7FFF_FFFF);
        push_edge(1);
        push_stamp(32'h5555_5555);
        push_stamp(32'hAAAA_AAAA);
        push_stamp(32'hFFFF_F000);
        push_edge(32'h0000_2000);
        gen_aligned = 1'b0;
        // All-zero and all-one codes, a threshold fault, then a frame right after a frame end.
        queue_frame('0, FAULT_NONE, FRAME_EDGES + 1);
        queue_frame(WORD_MAX, FAULT_NONE, FRAME_EDGES + 1);
        queue_frame(32'hA5A5_5A5A, FAULT_AT_THRESHOLD, FRAME_EDGES + 1);
        queue_frame(32'h0123_4567, FAULT_NONE, FRAME_EDGES + 1);
        wait_idle();

        // Short pulses, all four entries in use, two of them equal.
        codes = {WORD_MAX, 32'h0, 32'h0123_4567, 32'h0123_4567};
        program_regs(32'd1000, 32'd5000, 32'd100000, codes, 32'd4);
        queue_phase(4);
        wait_idle();

        // Widest settings with the entry count at seven; the receiver holds off meanwhile.
        codes = {$urandom(), $urandom(), 32'h0, WORD_MAX};
        program_regs(32'd1, WORD_MAX, WORD_MAX, codes, 32'hFFFF_FFFF);
        hold_request = 1'b1;
        queue_phase(10);
        wait_idle();

        // Threshold just below the top of the range.
        program_regs(32'hFFFF_FFFD, WORD_MAX, WORD_MAX, codes, 32'd5);
        queue_phase(4);
        wait_idle();

        // Smallest settings: only zero-length intervals stay inside a frame.
        program_regs(32'd1, 32'd1, 32'd1, codes, 32'd6);
        queue_phase(4);
        wait_idle();

        // Maximum below the threshold, so every one bit rejects the frame.
        program_regs(32'd1000000, 32'd5000, 32'd10000000, codes, 32'd2);
        queue_phase(4);
        wait_idle();

        // Random settings until enough edges and frames have gone through.
        random_base = edges_queued;
        while (edges_queued - random_base < RANDOM_EDGES || frames_queued < MIN_FRAMES) begin
            random_setup();
            queue_phase($urandom_range(6, 2));
            wait_idle();
        end

        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
